>>> hdl/poly_voice_allocator_top_macros.svh
// Assertion macros used by the checker file of the voice allocator.
// Every macro samples on the rising edge of clk and is off while arst_n is low.
`ifndef POLY_VOICE_ALLOCATOR_TOP_MACROS_SVH
`define POLY_VOICE_ALLOCATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PVA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PVA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/pva_pkg.sv
`default_nettype none

package pva_pkg;

	// Event kinds on the cmd input.
	localparam logic CMD_NOTE_ON  = 1'b0;
	localparam logic CMD_NOTE_OFF = 1'b1;

	// Action codes on the action output.
	localparam logic [1:0] ACT_START   = 2'd0;
	localparam logic [1:0] ACT_RELEASE = 2'd1;
	localparam logic [1:0] ACT_NONE    = 2'd2;

	// Note register value of a voice that holds no note.
	localparam logic [7:0] NOTE_UNASSIGNED = 8'h80;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ON_REMOVE,
		ST_ON_APPEND,
		ST_OFF_SCAN
	} state_t;

	// Commands broadcast to every cell of the age list.
	typedef struct packed {
		logic remove;
		logic append;
	} age_ctl_t;

	// Commands to one voice cell.
	typedef struct packed {
		logic wr;
		logic clr;
	} voice_ctl_t;

endpackage

`default_nettype wire

>>> hdl/pva_voice_cell.sv
`default_nettype none

// One voice: holds the note it was given and compares it with an event note.
module pva_voice_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pva_pkg::voice_ctl_t ctl,
	input  wire logic [6:0]        wr_note,
	input  wire logic [6:0]        cmp_note,
	output logic                   match
);

	logic [7:0] note_q;

	// A write assigns a note, a clear marks the voice unassigned.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_q <= pva_pkg::NOTE_UNASSIGNED;
		end else if (ctl.wr) begin
			note_q <= {1'b0, wr_note};
		end else if (ctl.clr) begin
			note_q <= pva_pkg::NOTE_UNASSIGNED;
		end
	end

	// An unassigned voice never matches, since its top bit is set.
	assign match = (note_q == {1'b0, cmp_note});

endmodule

`default_nettype wire

>>> hdl/pva_age_cell.sv
`default_nettype none

// One slot of the age list. Slot 0 is the oldest held voice. On a remove,
// the matching slot and every slot behind it take the word of the next slot,
// which closes the gap. On an append, the first empty slot takes the voice.
module pva_age_cell #(
	parameter int VW = 3
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pva_pkg::age_ctl_t ctl,
	input  wire logic [VW-1:0]     rm_voice,
	input  wire logic [VW-1:0]     ap_voice,
	input  wire logic              prev_valid,
	input  wire logic              shift_in,
	input  wire logic              next_valid,
	input  wire logic [VW-1:0]     next_voice,
	output logic                   valid,
	output logic [VW-1:0]          voice,
	output logic                   shift_out
);

	logic          valid_q;
	logic [VW-1:0] voice_q;
	logic          hit;
	logic          take_next;
	logic          take_new;

	// The shift request runs down the chain from the slot that matched.
	assign hit       = ctl.remove & valid_q & (voice_q == rm_voice);
	assign shift_out = shift_in | hit;
	assign take_next = ctl.remove & shift_out;
	assign take_new  = ctl.append & ~valid_q & prev_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_next) begin
			valid_q <= next_valid;
		end else if (take_new) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_next) begin
			voice_q <= next_voice;
		end else if (take_new) begin
			voice_q <= ap_voice;
		end
	end

	assign valid = valid_q;
	assign voice = voice_q;

endmodule

`default_nettype wire

>>> hdl/poly_voice_allocator_top.sv
// Channel   Direction  Handshake            Word
// event     in         start & !busy        cmd, note, voice_busy
// result    out        strobe, no stall     voice, action, note_out, last
//
// A note-on keeps busy high after it is taken, while it takes the
// voice out of the age list and then appends it as newest. Its result shows
// in the cycle after acceptance. A note-off scans the voices one per cycle,
// giving a release in the cycle after each match; busy lasts until the scan
// reaches the highest matching voice. A note-off without a match does not
// raise busy. Reset marks every voice unassigned and empties the list.
// The receiver cannot stall; every result is shown for exactly one cycle.
`default_nettype none

module poly_voice_allocator_top #(
	parameter int VOICES = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic       cmd,
	input  wire logic [6:0] note,
	input  wire logic [7:0] voice_busy,
	output logic            strobe,
	output logic [2:0]      voice,
	output logic [1:0]      action,
	output logic [6:0]      note_out,
	output logic            last
);

	localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

	pva_pkg::state_t   state_q;
	pva_pkg::state_t   state_d;
	pva_pkg::age_ctl_t age_ctl;

	logic [VW-1:0]     pick_q;
	logic [6:0]        note_q;
	logic [VOICES-1:0] mask_q;
	logic [VW-1:0]     idx_q;

	logic              accept;
	logic              acc_on;
	logic              acc_off;
	logic              off_miss;
	logic [VOICES-1:0] free_v;
	logic [VOICES-1:0] match_v;
	logic [VOICES-1:0] idx_oh;
	logic [VW-1:0]     pick_now;
	logic              found;
	logic              scan_hit;
	logic              scan_last;
	logic [VW-1:0]     rm_voice;

	logic              strobe_q;
	logic [2:0]        voice_q;
	logic [1:0]        action_q;
	logic [6:0]        note_out_q;
	logic              last_q;

	logic              cv_valid [VOICES+1];
	logic [VW-1:0]     cv_voice [VOICES+1];
	logic              cv_prev  [VOICES];
	logic              cv_shift [VOICES+1];

	// Reports a voice index modulo 8 on the three-bit voice output.
	function automatic logic [2:0] voice_mod8(input logic [VW-1:0] v);
		logic [VW+2:0] ext;
		ext = {3'b000, v};
		return ext[2:0];
	endfunction

	assign busy     = (state_q != pva_pkg::ST_IDLE);
	assign accept   = start & ~busy;
	assign acc_on   = accept & (cmd == pva_pkg::CMD_NOTE_ON);
	assign acc_off  = accept & (cmd == pva_pkg::CMD_NOTE_OFF);
	assign off_miss = acc_off & ~(|match_v);

	// Voices beyond the eight busy bits count as free.
	for (genvar i = 0; i < VOICES; i++) begin : g_free
		if (i < 8) begin : g_bit
			assign free_v[i] = ~voice_busy[i];
		end else begin : g_none
			assign free_v[i] = 1'b1;
		end
	end

	// Lowest free voice, else the oldest held voice, else voice 0.
	always_comb begin
		found    = 1'b0;
		pick_now = '0;
		for (int i = 0; i < VOICES; i++) begin
			if (!found && free_v[i]) begin
				found    = 1'b1;
				pick_now = VW'(i);
			end
		end
		if (!found && cv_valid[0]) begin
			pick_now = cv_voice[0];
		end
	end

	// Scan position and whether it is the final match.
	assign idx_oh    = VOICES'(1) << idx_q;
	assign scan_hit  = (state_q == pva_pkg::ST_OFF_SCAN) & mask_q[idx_q];
	assign scan_last = ~|(mask_q & ~idx_oh);

	// Row of voice cells.
	for (genvar i = 0; i < VOICES; i++) begin : g_voice
		pva_pkg::voice_ctl_t vctl;

		assign vctl.wr  = acc_on & (pick_now == VW'(i));
		assign vctl.clr = scan_hit & (idx_q == VW'(i));

		pva_voice_cell u_voice (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (vctl),
			.wr_note  (note),
			.cmp_note (note),
			.match    (match_v[i])
		);
	end

	// Chain of age list cells, oldest first.
	assign cv_valid[VOICES] = 1'b0;
	assign cv_voice[VOICES] = '0;
	assign cv_shift[0]      = 1'b0;
	assign cv_prev[0]       = 1'b1;

	for (genvar i = 1; i < VOICES; i++) begin : g_prev
		assign cv_prev[i] = cv_valid[i-1];
	end

	for (genvar i = 0; i < VOICES; i++) begin : g_age
		pva_age_cell #(
			.VW (VW)
		) u_age (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (age_ctl),
			.rm_voice   (rm_voice),
			.ap_voice   (pick_q),
			.prev_valid (cv_prev[i]),
			.shift_in   (cv_shift[i]),
			.next_valid (cv_valid[i+1]),
			.next_voice (cv_voice[i+1]),
			.valid      (cv_valid[i]),
			.voice      (cv_voice[i]),
			.shift_out  (cv_shift[i+1])
		);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pva_pkg::ST_IDLE: begin
				if (acc_on) begin
					state_d = pva_pkg::ST_ON_REMOVE;
				end else if (acc_off && (|match_v)) begin
					state_d = pva_pkg::ST_OFF_SCAN;
				end
			end
			pva_pkg::ST_ON_REMOVE: begin
				state_d = pva_pkg::ST_ON_APPEND;
			end
			pva_pkg::ST_ON_APPEND: begin
				state_d = pva_pkg::ST_IDLE;
			end
			pva_pkg::ST_OFF_SCAN: begin
				if (scan_hit && scan_last) begin
					state_d = pva_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pva_pkg::ST_IDLE;
			end
		endcase
	end

	// List commands for each state.
	always_comb begin
		age_ctl  = '0;
		rm_voice = pick_q;
		unique case (state_q)
			pva_pkg::ST_IDLE: begin
				age_ctl = '0;
			end
			pva_pkg::ST_ON_REMOVE: begin
				age_ctl.remove = 1'b1;
			end
			pva_pkg::ST_ON_APPEND: begin
				age_ctl.append = 1'b1;
			end
			pva_pkg::ST_OFF_SCAN: begin
				age_ctl.remove = mask_q[idx_q];
				rm_voice       = idx_q;
			end
			default: begin
				age_ctl = '0;
			end
		endcase
	end

	// Control registers. A note-off with matches gives its words from the scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= pva_pkg::ST_IDLE;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= acc_on | off_miss | scan_hit;
		end
	end

	// Event context and result word.
	always_ff @(posedge clk) begin
		if (accept) begin
			pick_q <= pick_now;
			note_q <= note;
			mask_q <= match_v;
			idx_q  <= '0;
		end else if (state_q == pva_pkg::ST_OFF_SCAN) begin
			mask_q <= mask_q & ~idx_oh;
			idx_q  <= idx_q + VW'(1);
		end

		if (acc_on) begin
			voice_q    <= voice_mod8(pick_now);
			action_q   <= pva_pkg::ACT_START;
			note_out_q <= note;
			last_q     <= 1'b1;
		end else if (off_miss) begin
			voice_q    <= '0;
			action_q   <= pva_pkg::ACT_NONE;
			note_out_q <= note;
			last_q     <= 1'b1;
		end else if (scan_hit) begin
			voice_q    <= voice_mod8(idx_q);
			action_q   <= pva_pkg::ACT_RELEASE;
			note_out_q <= note_q;
			last_q     <= scan_last;
		end
	end

	assign strobe   = strobe_q;
	assign voice    = voice_q;
	assign action   = action_q;
	assign note_out = note_out_q;
	assign last     = last_q;

endmodule

`default_nettype wire

>>> hdl/pva_checker.sv
`default_nettype none

`include "poly_voice_allocator_top_macros.svh"

// Port-level checks of the voice allocator's result sequencing.
module pva_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       cmd,
	input wire logic [6:0] note,
	input wire logic [7:0] voice_busy,
	input wire logic       strobe,
	input wire logic [2:0] voice,
	input wire logic [1:0] action,
	input wire logic [6:0] note_out,
	input wire logic       last
);

	logic accept;

	assign accept = start & ~busy;

	// A note-on gives a single start word right after it is taken.
	`PVA_ASSERT_NEXT(a_note_on_result, accept && (cmd == pva_pkg::CMD_NOTE_ON), strobe && (action == pva_pkg::ACT_START) && last && (note_out == $past(note)), "note-on did not give one start word")

	// A note-off either finishes at once with a final word or keeps the block busy.
	`PVA_ASSERT_NEXT(a_note_off_progress, accept && (cmd == pva_pkg::CMD_NOTE_OFF), busy || (strobe && last), "note-off gave neither a final word nor busy")

	// An unmatched note-off reports voice 0 as its only word.
	`PVA_ASSERT_SAME(a_no_action_word, strobe && (action == pva_pkg::ACT_NONE), last && (voice == 3'd0), "no-action word is not a final word on voice 0")

	// More release words are pending, so no new event may be taken.
	`PVA_ASSERT_SAME(a_pending_busy, strobe && !last, busy && (action == pva_pkg::ACT_RELEASE), "non-final word while the block is idle")

endmodule

bind poly_voice_allocator_top pva_checker u_pva_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.cmd        (cmd),
	.note       (note),
	.voice_busy (voice_busy),
	.strobe     (strobe),
	.voice      (voice),
	.action     (action),
	.note_out   (note_out),
	.last       (last)
);

`default_nettype wire
